// ===== hdl/nrsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nrsr_pkg
// shared types and constants of the newton-raphson square root unit
// ----------------------------------------------------------------------------
`default_nettype none

package nrsr_pkg;

    // estimate width, product and numerator width
    localparam int XW     = 32;
    localparam int NUM_W  = 2 * XW;
    localparam int RAD_W  = 32;
    localparam int ROOT_W = 24;
    localparam int ST_W   = 2;
    localparam int ITER_W = 6;
    localparam int TOL_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CNT_W  = $clog2(XW);

    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    // status codes
    localparam logic [ST_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [ST_W-1:0] ST_NEGATIVE  = 2'd1;
    localparam logic [ST_W-1:0] ST_LIMIT     = 2'd2;

    // configuration register indexes
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_ITER_LIMIT = 1'b1;

    localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd7;
    localparam logic [ITER_W-1:0] LIMIT_RESET = 6'd32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_CHECK,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/newton_raphson_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// newton_raphson_square_root_unit
// fixed-point square root by newton iteration on one shared multiply/divide
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries a signed fixed-point radicand; m_tdata returns the
//   unsigned root, a status code and the iteration count. one item at a
//   time: s_tready is high only while the unit is idle.
//   each newton step runs x' = (x*x + a<<FRAC_BITS) / (2x) on one 32x32
//   multiplier, one wide add and a restoring divider that makes one
//   quotient bit per cycle, then a compare step. a negative or zero
//   radicand gives its result in the cycle after accept.
//   the iteration stops when successive estimates differ by less than the
//   tolerance register, or when the iteration limit is reached.
//   the result is held in an output register until m_tready; the next
//   item is accepted after the result is taken.
//   reset returns to idle and loads tolerance 7 and iteration limit 32.
//   configuration writes are taken any cycle through cfg_wr_en.
// ----------------------------------------------------------------------------
`default_nettype none

module newton_raphson_square_root_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration write port
    input  wire                          cfg_wr_en,
    input  wire                          cfg_index,
    input  wire  [nrsr_pkg::CFG_W-1:0]   cfg_data,
    // input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [nrsr_pkg::RAD_W-1:0]   s_tdata,   // [31:0] radicand
    // output stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [31:0]                  m_tdata    // [23:0] root, [25:24] status,
                                                    // [31:26] iterations_used
);

    import nrsr_pkg::*;

    state_t state_reg, state_next;

    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] lim_reg;

    logic [RAD_W-2:0]  raw_reg, raw_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [NUM_W-1:0]  prod_reg, prod_next;
    logic [XW:0]       den_reg, den_next;
    logic [XW:0]       rem_reg, rem_next;
    logic [XW-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ITER_W-1:0] used_reg, used_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ST_W-1:0]   status_reg, status_next;

    logic              in_fire;
    logic [NUM_W-1:0]  num;
    logic [XW+1:0]     trial;
    logic              trial_ge;
    logic [XW-1:0]     diff;
    logic [ITER_W-1:0] used_inc;
    logic [ITER_W-1:0] lim_eff;
    logic              converged;
    logic              at_limit;

    assign in_fire = s_tvalid && s_tready;

    // numerator and one restoring divide step
    assign num      = prod_reg + ({{(NUM_W-RAD_W+1){1'b0}}, raw_reg} << FRAC_BITS);
    assign trial    = {rem_reg, quo_reg[XW-1]} - {1'b0, den_reg};
    assign trial_ge = !trial[XW+1];

    assign diff      = (quo_reg >= x_reg) ? (quo_reg - x_reg) : (x_reg - quo_reg);
    assign used_inc  = used_reg + 1'b1;
    assign lim_eff   = (lim_reg == '0) ? {{(ITER_W-1){1'b0}}, 1'b1} : lim_reg;
    assign converged = diff < {{(XW-TOL_W){1'b0}}, tol_reg};
    assign at_limit  = used_inc >= lim_eff;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tdata[RAD_W-1] || s_tdata == '0)
                        state_next = S_OUT;
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(XW - 1))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (converged || at_limit)
                    state_next = S_OUT;
                else
                    state_next = S_MUL;
            end
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_OUT:   m_tvalid = 1'b1;
            default:
            begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    assign m_tdata = {used_reg, status_reg, root_reg};

    // datapath
    always_comb
    begin
        raw_next    = raw_reg;
        x_next      = x_reg;
        prod_next   = prod_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        used_next   = used_reg;
        root_next   = root_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    raw_next  = s_tdata[RAD_W-2:0];
                    x_next    = XW'(s_tdata[RAD_W-2:0]);
                    used_next = '0;
                    root_next = '0;
                    if (s_tdata[RAD_W-1])
                        status_next = ST_NEGATIVE;
                    else
                        status_next = ST_CONVERGED;
                end
            end
            S_MUL:
            begin
                prod_next = x_reg * x_reg;
                den_next  = {x_reg, 1'b0};
            end
            S_ADD:
            begin
                // upper half is below the divisor, so the quotient fits xw bits
                rem_next = {1'b0, num[NUM_W-1:XW]};
                quo_next = num[XW-1:0];
                cnt_next = '0;
            end
            S_DIV:
            begin
                rem_next = trial_ge ? trial[XW:0] : {rem_reg[XW-1:0], quo_reg[XW-1]};
                quo_next = {quo_reg[XW-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            S_CHECK:
            begin
                used_next = used_inc;
                x_next    = quo_reg;
                if (converged || at_limit)
                begin
                    status_next = converged ? ST_CONVERGED : ST_LIMIT;
                    root_next   = (|quo_reg[XW-1:ROOT_W]) ? ROOT_MAX : quo_reg[ROOT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tol_reg   <= TOL_RESET;
            lim_reg   <= LIMIT_RESET;
            cnt_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            used_reg  <= used_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_TOLERANCE:  tol_reg <= cfg_data;
                    REG_ITER_LIMIT: lim_reg <= cfg_data[ITER_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= raw_next;
        x_reg      <= x_next;
        prod_reg   <= prod_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        root_reg   <= root_next;
        status_reg <= status_next;
    end

    // the two sides never both open at once
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // divider partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // a negative radicand is answered on the next cycle
    a_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tdata[RAD_W-1]) |=>
            (m_tvalid && m_tdata[ROOT_W+ST_W-1:ROOT_W] == ST_NEGATIVE))
        else $error("negative radicand not reported");

    // a limit result always has run at least one iteration
    a_limit_used: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[ROOT_W+ST_W-1:ROOT_W] == ST_LIMIT) |->
            (m_tdata[31:ROOT_W+ST_W] != '0))
        else $error("limit status with no iteration");

endmodule

`default_nettype wire
